FILE: src/sae_pkg.sv
// shared constants, codes, control structs and helpers of the adjacency edge store
`default_nettype none
package sae_pkg;

   // graph size and derived widths
   localparam int MAX_VERTICES = 64;
   localparam int CMD_W        = 2;
   localparam int VTX_W        = 6;
   localparam int SLOT_W       = 6;
   localparam int ST_W         = 3;
   localparam int DEG_W        = 7;
   localparam int EDGE_W       = 12;
   localparam int ACT_W        = 7;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int ROW_DEPTH    = MAX_VERTICES * MAX_VERTICES;
   localparam int ROW_AW       = $clog2(ROW_DEPTH);

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD    = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_REMOVE = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_READ   = CMD_W'(2);

   // result status codes
   typedef enum logic [ST_W-1:0] {
      ST_OK     = 3'd0,
      ST_FULL   = 3'd1,
      ST_ABSENT = 3'd2,
      ST_SELF   = 3'd3,
      ST_SLOT   = 3'd4
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load_req;
      logic       deg_rd_a;
      logic       deg_rd_b;
      logic       cap_deg_a;
      logic       cap_deg_b;
      logic       set_side;
      logic       side;
      logic       ins_start;
      logic       ins_step;
      logic       ins_put;
      logic       find_start;
      logic       find_step;
      logic       del_start;
      logic       del_step;
      logic       slot_rd;
      logic       upd_a;
      logic       upd_b;
      logic       set_status;
      status_type status;
      logic       load_rsp;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_add;
      logic is_remove;
      logic is_read;
      logic self_loop;
      logic add_full;
      logic ep_missing;
      logic slot_bad;
      logic n_zero;
      logic shift;
      logic ptr_zero;
      logic match;
      logic last;
      logic del_none;
      logic side;
      logic rsp_free;
   } dp_stat_type;

   // vertex lies inside the graph
   function automatic logic vtx_ok(input logic [VTX_W-1:0] v);
      return int'(v) < MAX_VERTICES;
   endfunction

   // flat address of one entry of a neighbor row
   function automatic logic [ROW_AW-1:0] row_addr(input logic [VTX_W-1:0] row,
                                                  input logic [IDX_W-1:0] idx);
      return ROW_AW'(row) * ROW_AW'(MAX_VERTICES) + ROW_AW'(idx);
   endfunction

endpackage
`default_nettype wire

FILE: src/sae_req_if.sv
// command channel interface: valid, ready and one command beat
`default_nettype none
interface sae_req_if;
   logic                        valid;
   logic                        ready;
   logic [sae_pkg::CMD_W-1:0]   command;
   logic [sae_pkg::VTX_W-1:0]   vertex_a;
   logic [sae_pkg::VTX_W-1:0]   vertex_b;
   logic [sae_pkg::SLOT_W-1:0]  slot;

   modport source(output valid, command, vertex_a, vertex_b, slot, input ready);
   modport sink(input valid, command, vertex_a, vertex_b, slot, output ready);
endinterface
`default_nettype wire

FILE: src/sae_rsp_if.sv
// result channel interface: valid, ready and one result beat
`default_nettype none
interface sae_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sae_pkg::ST_W-1:0]    status;
   logic [sae_pkg::VTX_W-1:0]   neighbor;
   logic [sae_pkg::DEG_W-1:0]   degree_a;
   logic [sae_pkg::DEG_W-1:0]   degree_b;
   logic [sae_pkg::EDGE_W-1:0]  edge_count;
   logic [sae_pkg::ACT_W-1:0]   vertex_count;

   modport source(output valid, status, neighbor, degree_a, degree_b, edge_count,
                  vertex_count, input ready);
   modport sink(input valid, status, neighbor, degree_a, degree_b, edge_count,
                vertex_count, output ready);
endinterface
`default_nettype wire

FILE: src/sae_ctrl.sv
// sequencing state machine of the adjacency edge store
`default_nettype none
module sae_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sae_pkg::dp_stat_type stat,
   output sae_pkg::dp_cmd_type       cmd
);

   typedef enum logic [15:0] {
      S_IDLE       = 16'b0000_0000_0000_0001,
      S_DEG_A      = 16'b0000_0000_0000_0010,
      S_DEG_B      = 16'b0000_0000_0000_0100,
      S_DEG_CAP    = 16'b0000_0000_0000_1000,
      S_DECIDE     = 16'b0000_0000_0001_0000,
      S_INS_START  = 16'b0000_0000_0010_0000,
      S_INS_LOOP   = 16'b0000_0000_0100_0000,
      S_INS_PUT    = 16'b0000_0000_1000_0000,
      S_FIND_START = 16'b0000_0001_0000_0000,
      S_FIND_LOOP  = 16'b0000_0010_0000_0000,
      S_DEL_START  = 16'b0000_0100_0000_0000,
      S_DEL_LOOP   = 16'b0000_1000_0000_0000,
      S_SLOT_RD    = 16'b0001_0000_0000_0000,
      S_UPD_A      = 16'b0010_0000_0000_0000,
      S_UPD_B      = 16'b0100_0000_0000_0000,
      S_FINISH     = 16'b1000_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // no beat is taken while reset is held
   assign req_ready = (state_ff == S_IDLE) && !reset;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load_req = 1'b1;
               state_in     = S_DEG_A;
            end
         end
         S_DEG_A: begin
            cmd.deg_rd_a = 1'b1;
            state_in     = S_DEG_B;
         end
         S_DEG_B: begin
            cmd.cap_deg_a = 1'b1;
            cmd.deg_rd_b  = 1'b1;
            state_in      = S_DEG_CAP;
         end
         S_DEG_CAP: begin
            cmd.cap_deg_b = 1'b1;
            state_in      = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.set_status = 1'b1;
            cmd.status     = sae_pkg::ST_OK;
            cmd.set_side   = 1'b1;
            cmd.side       = 1'b0;
            state_in       = S_FINISH;
            if (stat.is_add) begin
               if (stat.self_loop) begin
                  cmd.status = sae_pkg::ST_SELF;
               end else if (stat.add_full) begin
                  cmd.status = sae_pkg::ST_FULL;
               end else begin
                  state_in = S_INS_START;
               end
            end else if (stat.is_remove) begin
               if (stat.self_loop) begin
                  cmd.status = sae_pkg::ST_SELF;
               end else if (stat.ep_missing) begin
                  cmd.status = sae_pkg::ST_ABSENT;
               end else begin
                  state_in = S_FIND_START;
               end
            end else if (stat.is_read) begin
               if (stat.slot_bad) begin
                  cmd.status = sae_pkg::ST_SLOT;
               end else begin
                  state_in = S_SLOT_RD;
               end
            end
         end
         // insert walks down from the top of the row shifting entries up
         S_INS_START: begin
            cmd.ins_start = 1'b1;
            state_in      = stat.n_zero ? S_INS_PUT : S_INS_LOOP;
         end
         S_INS_LOOP: begin
            cmd.ins_step = 1'b1;
            if (stat.shift && stat.ptr_zero) begin
               state_in = S_INS_PUT;
            end else if (!stat.shift) begin
               if (stat.side) begin
                  state_in = S_UPD_A;
               end else begin
                  cmd.set_side = 1'b1;
                  cmd.side     = 1'b1;
                  state_in     = S_INS_START;
               end
            end
         end
         S_INS_PUT: begin
            cmd.ins_put = 1'b1;
            if (stat.side) begin
               state_in = S_UPD_A;
            end else begin
               cmd.set_side = 1'b1;
               cmd.side     = 1'b1;
               state_in     = S_INS_START;
            end
         end
         // search both rows before anything is changed
         S_FIND_START: begin
            if (stat.n_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = sae_pkg::ST_ABSENT;
               state_in       = S_FINISH;
            end else begin
               cmd.find_start = 1'b1;
               state_in       = S_FIND_LOOP;
            end
         end
         S_FIND_LOOP: begin
            cmd.find_step = 1'b1;
            if (stat.match) begin
               cmd.set_side = 1'b1;
               cmd.side     = !stat.side;
               state_in     = stat.side ? S_DEL_START : S_FIND_START;
            end else if (stat.last) begin
               cmd.set_status = 1'b1;
               cmd.status     = sae_pkg::ST_ABSENT;
               state_in       = S_FINISH;
            end
         end
         // delete walks up from the match shifting entries down
         S_DEL_START: begin
            if (stat.del_none) begin
               if (stat.side) begin
                  state_in = S_UPD_A;
               end else begin
                  cmd.set_side = 1'b1;
                  cmd.side     = 1'b1;
                  state_in     = S_DEL_START;
               end
            end else begin
               cmd.del_start = 1'b1;
               state_in      = S_DEL_LOOP;
            end
         end
         S_DEL_LOOP: begin
            cmd.del_step = 1'b1;
            if (stat.last) begin
               if (stat.side) begin
                  state_in = S_UPD_A;
               end else begin
                  cmd.set_side = 1'b1;
                  cmd.side     = 1'b1;
                  state_in     = S_DEL_START;
               end
            end
         end
         S_SLOT_RD: begin
            cmd.slot_rd = 1'b1;
            state_in    = S_FINISH;
         end
         S_UPD_A: begin
            cmd.upd_a = 1'b1;
            state_in  = S_UPD_B;
         end
         S_UPD_B: begin
            cmd.upd_b = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: src/sae_dp.sv
// datapath: neighbor row memory, degree memory, counters and result register
`default_nettype none
module sae_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sae_pkg::dp_cmd_type           cmd,
   output sae_pkg::dp_stat_type               stat,
   input  wire logic [sae_pkg::CMD_W-1:0]     req_command,
   input  wire logic [sae_pkg::VTX_W-1:0]     req_vertex_a,
   input  wire logic [sae_pkg::VTX_W-1:0]     req_vertex_b,
   input  wire logic [sae_pkg::SLOT_W-1:0]    req_slot,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [sae_pkg::ST_W-1:0]           rsp_status,
   output logic [sae_pkg::VTX_W-1:0]          rsp_neighbor,
   output logic [sae_pkg::DEG_W-1:0]          rsp_degree_a,
   output logic [sae_pkg::DEG_W-1:0]          rsp_degree_b,
   output logic [sae_pkg::EDGE_W-1:0]         rsp_edge_count,
   output logic [sae_pkg::ACT_W-1:0]          rsp_vertex_count
);

   localparam int DW = sae_pkg::DEG_W;
   localparam int VW = sae_pkg::VTX_W;
   localparam int IW = sae_pkg::IDX_W;

   // latched command
   logic [sae_pkg::CMD_W-1:0]  cmd_ff;
   logic [VW-1:0]              a_ff, b_ff;
   logic [sae_pkg::SLOT_W-1:0] slot_ff;
   logic [DW-1:0]              deg_a_ff, deg_a_in;
   logic [DW-1:0]              deg_b_ff, deg_b_in;
   logic                       side_ff;
   logic [DW-1:0]              ptr_ff, ptr_in;
   logic [IW-1:0]              pos_a_ff, pos_b_ff;
   sae_pkg::status_type        status_ff;
   logic [sae_pkg::EDGE_W-1:0] edge_ff, edge_in;
   logic [sae_pkg::ACT_W-1:0]  active_ff, active_in;

   // memories
   logic [VW-1:0] row_mem [sae_pkg::ROW_DEPTH];
   logic [VW-1:0] rd_data_ff;
   logic [DW-1:0] deg_mem [sae_pkg::MAX_VERTICES];
   logic [sae_pkg::MAX_VERTICES-1:0] deg_valid_ff;
   logic [DW-1:0] deg_q_ff;
   logic          deg_qv_ff;

   logic                         rsp_valid_ff;
   logic [sae_pkg::ST_W-1:0]     rsp_status_ff;
   logic [VW-1:0]                rsp_nb_ff;
   logic [DW-1:0]                rsp_deg_a_ff, rsp_deg_b_ff;
   logic [sae_pkg::EDGE_W-1:0]   rsp_edge_ff;
   logic [sae_pkg::ACT_W-1:0]    rsp_act_ff;

   logic [VW-1:0]     cur_row, cur_val, rd_row;
   logic [DW-1:0]     cur_n, deg_val, new_a, new_b;
   logic [IW-1:0]     cur_pos;
   logic [DW-1:0]     ptr_inc, ptr_dec, pos_inc;
   logic              is_add, is_remove, is_read;
   logic              mem_we, mem_re;
   logic [DW-1:0]     mem_widx, mem_ridx;
   logic [VW-1:0]     mem_wdata;
   logic [sae_pkg::ROW_AW-1:0] mem_waddr, mem_raddr;
   logic              deg_re, deg_we;
   logic [IW-1:0]     deg_raddr, deg_waddr;
   logic [DW-1:0]     deg_wdata;

   // row currently worked on: row of a holds b, row of b holds a
   assign cur_row = side_ff ? b_ff : a_ff;
   assign cur_val = side_ff ? a_ff : b_ff;
   assign cur_n   = side_ff ? deg_b_ff : deg_a_ff;
   assign cur_pos = side_ff ? pos_b_ff : pos_a_ff;
   assign ptr_inc = ptr_ff + DW'(1);
   assign ptr_dec = ptr_ff - DW'(1);
   assign pos_inc = DW'(cur_pos) + DW'(1);

   assign is_add    = (cmd_ff == sae_pkg::CMD_ADD);
   assign is_remove = (cmd_ff == sae_pkg::CMD_REMOVE);
   assign is_read   = (cmd_ff == sae_pkg::CMD_READ);

   assign deg_val = deg_qv_ff ? deg_q_ff : '0;
   assign new_a   = is_add ? deg_a_ff + DW'(1) : deg_a_ff - DW'(1);
   assign new_b   = is_add ? deg_b_ff + DW'(1) : deg_b_ff - DW'(1);

   // status toward the controller
   always_comb begin
      stat            = '0;
      stat.is_add     = is_add;
      stat.is_remove  = is_remove;
      stat.is_read    = is_read;
      stat.self_loop  = (a_ff == b_ff);
      stat.add_full   = !sae_pkg::vtx_ok(a_ff) || !sae_pkg::vtx_ok(b_ff) ||
                        (deg_a_ff >= DW'(sae_pkg::MAX_VERTICES)) ||
                        (deg_b_ff >= DW'(sae_pkg::MAX_VERTICES));
      stat.ep_missing = !sae_pkg::vtx_ok(a_ff) || !sae_pkg::vtx_ok(b_ff);
      stat.slot_bad   = (DW'(slot_ff) >= deg_a_ff);
      stat.n_zero     = (cur_n == '0);
      stat.shift      = (rd_data_ff >= cur_val);
      stat.ptr_zero   = (ptr_ff == '0);
      stat.match      = (rd_data_ff == cur_val);
      stat.last       = (ptr_inc >= cur_n);
      stat.del_none   = (pos_inc >= cur_n);
      stat.side       = side_ff;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // row memory access for insert, search, delete and slot read
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_widx  = '0;
      mem_ridx  = '0;
      mem_wdata = cur_val;
      rd_row    = cur_row;
      ptr_in    = ptr_ff;
      if (cmd.ins_start) begin
         if (cur_n != '0) begin
            mem_re   = 1'b1;
            mem_ridx = cur_n - DW'(1);
            ptr_in   = cur_n - DW'(1);
         end else begin
            ptr_in = '0;
         end
      end
      if (cmd.ins_step) begin
         mem_we   = 1'b1;
         mem_widx = ptr_inc;
         if (stat.shift) begin
            mem_wdata = rd_data_ff;
            if (!stat.ptr_zero) begin
               mem_re   = 1'b1;
               mem_ridx = ptr_dec;
               ptr_in   = ptr_dec;
            end
         end
      end
      if (cmd.ins_put) begin
         mem_we   = 1'b1;
         mem_widx = ptr_ff;
      end
      if (cmd.find_start) begin
         mem_re = 1'b1;
         ptr_in = '0;
      end
      if (cmd.find_step && !stat.match && !stat.last) begin
         mem_re   = 1'b1;
         mem_ridx = ptr_inc;
         ptr_in   = ptr_inc;
      end
      if (cmd.del_start && !stat.del_none) begin
         mem_re   = 1'b1;
         mem_ridx = pos_inc;
         ptr_in   = pos_inc;
      end
      if (cmd.del_step) begin
         mem_we    = 1'b1;
         mem_widx  = ptr_dec;
         mem_wdata = rd_data_ff;
         if (!stat.last) begin
            mem_re   = 1'b1;
            mem_ridx = ptr_inc;
            ptr_in   = ptr_inc;
         end
      end
      if (cmd.slot_rd) begin
         mem_re   = 1'b1;
         rd_row   = a_ff;
         mem_ridx = DW'(slot_ff);
      end
   end

   assign mem_waddr = sae_pkg::row_addr(cur_row, mem_widx[IW-1:0]);
   assign mem_raddr = sae_pkg::row_addr(rd_row, mem_ridx[IW-1:0]);

   // neighbor row memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= row_mem[mem_raddr];
      end
   end

   // degree memory access
   assign deg_re    = cmd.deg_rd_a || cmd.deg_rd_b;
   assign deg_raddr = cmd.deg_rd_b ? b_ff[IW-1:0] : a_ff[IW-1:0];
   assign deg_we    = cmd.upd_a || cmd.upd_b;
   assign deg_waddr = cmd.upd_b ? b_ff[IW-1:0] : a_ff[IW-1:0];
   assign deg_wdata = cmd.upd_b ? new_b : new_a;

   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[deg_waddr] <= deg_wdata;
      end
      if (deg_re) begin
         deg_q_ff <= deg_mem[deg_raddr];
      end
   end

   // entries never written read as zero degree
   always_ff @(posedge clock) begin
      if (reset) begin
         deg_valid_ff <= '0;
         deg_qv_ff    <= 1'b0;
      end else begin
         if (deg_we) begin
            deg_valid_ff[deg_waddr] <= 1'b1;
         end
         if (deg_re) begin
            deg_qv_ff <= deg_valid_ff[deg_raddr];
         end
      end
   end

   // degree and counter updates
   always_comb begin
      deg_a_in  = deg_a_ff;
      deg_b_in  = deg_b_ff;
      edge_in   = edge_ff;
      active_in = active_ff;
      if (cmd.cap_deg_a) begin
         deg_a_in = deg_val;
      end
      if (cmd.cap_deg_b) begin
         deg_b_in = deg_val;
      end
      if (cmd.upd_a) begin
         deg_a_in = new_a;
         if (is_add && deg_a_ff == '0) begin
            active_in = active_ff + sae_pkg::ACT_W'(1);
         end else if (!is_add && deg_a_ff == DW'(1)) begin
            active_in = active_ff - sae_pkg::ACT_W'(1);
         end
      end
      if (cmd.upd_b) begin
         deg_b_in = new_b;
         edge_in  = is_add ? edge_ff + sae_pkg::EDGE_W'(1) : edge_ff - sae_pkg::EDGE_W'(1);
         if (is_add && deg_b_ff == '0) begin
            active_in = active_ff + sae_pkg::ACT_W'(1);
         end else if (!is_add && deg_b_ff == DW'(1)) begin
            active_in = active_ff - sae_pkg::ACT_W'(1);
         end
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff   <= '0;
         active_ff <= '0;
      end else begin
         edge_ff   <= edge_in;
         active_ff <= active_in;
      end
   end

   // command latch and working registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff  <= req_command;
         a_ff    <= req_vertex_a;
         b_ff    <= req_vertex_b;
         slot_ff <= req_slot;
      end
      if (cmd.set_side) begin
         side_ff <= cmd.side;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.find_step && stat.match) begin
         if (side_ff) begin
            pos_b_ff <= ptr_ff[IW-1:0];
         end else begin
            pos_a_ff <= ptr_ff[IW-1:0];
         end
      end
      deg_a_ff <= deg_a_in;
      deg_b_ff <= deg_b_in;
      ptr_ff   <= ptr_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_nb_ff     <= (is_read && status_ff == sae_pkg::ST_OK) ? rd_data_ff : '0;
         rsp_deg_a_ff  <= deg_a_ff;
         rsp_deg_b_ff  <= deg_b_ff;
         rsp_edge_ff   <= edge_ff;
         rsp_act_ff    <= active_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_neighbor     = rsp_nb_ff;
   assign rsp_degree_a     = rsp_deg_a_ff;
   assign rsp_degree_b     = rsp_deg_b_ff;
   assign rsp_edge_count   = rsp_edge_ff;
   assign rsp_vertex_count = rsp_act_ff;

endmodule
`default_nettype wire

FILE: src/sorted_adjacency_edge_store_core.sv
// top level of the sorted adjacency edge store
//
// Keeps an undirected multigraph as one ascending neighbor row per vertex.
// Command beats arrive on req_ch (add edge, remove edge, read neighbor slot);
// every command gives exactly one result beat on rsp_ch with a status, the
// neighbor for a read, both endpoint degrees, the edge count and the count of
// vertices with nonzero degree, all as they stand after the command.
// One command is worked on at a time; req_ch.ready is high only while idle
// and out of reset, so the next beat is taken only once the result of the
// last one has loaded. The single neighbor row memory is walked one entry
// per cycle for search and shift.
// Reset clears degrees, edge count and vertex count; row memory contents are
// not cleared and need no clearing pass, since only entries below a degree
// are ever read. A finished result waits in the output register while
// rsp_ch.ready is low; the next command is taken meanwhile and its result
// waits until the register frees up.
`default_nettype none
module sorted_adjacency_edge_store_core (
   input  wire logic  clock,
   input  wire logic  reset,
   sae_req_if.sink    req_ch,
   sae_rsp_if.source  rsp_ch
);

   sae_pkg::dp_cmd_type  dp_cmd;
   sae_pkg::dp_stat_type dp_stat;

   // sequencer
   sae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // storage and arithmetic
   sae_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .stat             (dp_stat),
      .req_command      (req_ch.command),
      .req_vertex_a     (req_ch.vertex_a),
      .req_vertex_b     (req_ch.vertex_b),
      .req_slot         (req_ch.slot),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_status       (rsp_ch.status),
      .rsp_neighbor     (rsp_ch.neighbor),
      .rsp_degree_a     (rsp_ch.degree_a),
      .rsp_degree_b     (rsp_ch.degree_b),
      .rsp_edge_count   (rsp_ch.edge_count),
      .rsp_vertex_count (rsp_ch.vertex_count)
   );

endmodule
`default_nettype wire

FILE: src/sae_checker.sv
// port-level checks of the edge store and their bind to the top level
`default_nettype none
module sae_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [sae_pkg::ST_W-1:0]     status,
   input wire logic [sae_pkg::VTX_W-1:0]    neighbor,
   input wire logic [sae_pkg::DEG_W-1:0]    degree_a,
   input wire logic [sae_pkg::DEG_W-1:0]    degree_b,
   input wire logic [sae_pkg::EDGE_W-1:0]   edge_count,
   input wire logic [sae_pkg::ACT_W-1:0]    vertex_count
);

   // no result beat right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result beat stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(edge_count))
      else $error("stalled result changed");

   // neighbor is zero unless the command succeeded
   a_nb_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != sae_pkg::ST_OK |-> neighbor == '0)
      else $error("neighbor nonzero on failed command");

   // edges exist exactly when some vertex has a neighbor
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (edge_count == '0) == (vertex_count == '0))
      else $error("edge and vertex counts disagree");

   // a self loop names one vertex twice
   a_self: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == sae_pkg::ST_SELF |-> degree_a == degree_b)
      else $error("self loop with differing degrees");

endmodule

bind sorted_adjacency_edge_store_core sae_checker u_sae_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .status       (rsp_ch.status),
   .neighbor     (rsp_ch.neighbor),
   .degree_a     (rsp_ch.degree_a),
   .degree_b     (rsp_ch.degree_b),
   .edge_count   (rsp_ch.edge_count),
   .vertex_count (rsp_ch.vertex_count)
);
`default_nettype wire
